### rtl/pbcz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcz_pkg
// Shared types and constants for the back-face cull / mean depth block.
// ----------------------------------------------------------------------------
package pbcz_pkg;

    localparam int MAX_VERTICES = 4;

    localparam int IDX_W   = 9;
    localparam int COORD_W = 32;
    localparam int CNT_W   = 3;
    localparam int SLOT_W  = 9;
    localparam int VCNT_W  = 10;

    localparam int IN_W  = 304;  // 300 field bits, padded to bytes
    localparam int OUT_W = 56;   // 50 field bits, padded to bytes

    // Shared multiplier operand width and product width
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 66;

    // ceil(2^33 / 3): exact floor(m / 3) for m < 2^33 via (m * RECIP3) >> 33
    localparam logic signed [MUL_W-1:0] RECIP3   = 34'sh0_AAAA_AAAB;
    localparam int                      RECIP3_SH = 33;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MX,
        S_MY,
        S_MZ,
        S_MD,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_DIV
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic dot_neg;
        logic out_free;
    } t_stat;

endpackage

### rtl/pbcz_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcz_ctrl
// Sequencer: accepts an item, walks the three dot-product terms and the
// divide-by-three product through the shared multiplier, then emits or drops.
// ----------------------------------------------------------------------------
module pbcz_ctrl
    import pbcz_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_MX;
            end
            S_MX: n_state = S_MY;
            S_MY: n_state = S_MZ;
            S_MZ: n_state = S_MD;
            S_MD: n_state = S_FIN;
            S_FIN: begin
                // culled items leave at once; visible ones wait for the output register
                if (i_stat.dot_neg || i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.mul_en  = 1'b0;
        o_cmd.mul_sel = MUL_X;
        o_cmd.acc_op  = ACC_HOLD;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_MX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_X;
            end
            S_MY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_Y;
                o_cmd.acc_op  = ACC_LOAD;
            end
            S_MZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_Z;
                o_cmd.acc_op  = ACC_ADD;
            end
            S_MD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DIV;
                o_cmd.acc_op  = ACC_ADD;
            end
            S_FIN: begin
                o_cmd.emit = !i_stat.dot_neg && i_stat.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/pbcz_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcz_dpath
// Operand registers, shared 34x34 multiplier, dot accumulator, mean depth,
// visible counter and the output register.
// ----------------------------------------------------------------------------
module pbcz_dpath
    import pbcz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [IN_W-1:0]  i_tdata,
    input  logic             i_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    // input fields
    logic        [IDX_W-1:0]   w_index;
    logic signed [COORD_W-1:0] w_nx, w_ny, w_nz, w_px, w_py;
    logic        [CNT_W-1:0]   w_vcount;
    logic signed [COORD_W-1:0] w_da, w_db, w_dc, w_dd;

    assign w_index  = i_tdata[8:0];
    assign w_nx     = i_tdata[40:9];
    assign w_ny     = i_tdata[72:41];
    assign w_nz     = i_tdata[104:73];
    assign w_px     = i_tdata[136:105];
    assign w_py     = i_tdata[168:137];
    assign w_vcount = i_tdata[171:169];
    assign w_da     = i_tdata[203:172];
    assign w_db     = i_tdata[235:204];
    assign w_dc     = i_tdata[267:236];
    assign w_dd     = i_tdata[299:268];

    // direction and negated pivot, 33 bits each
    logic signed [COORD_W:0] w_dx, w_dy, w_dz, w_ngx, w_ngy, w_ngz;
    assign w_dx  = 33'(w_nx) - 33'(w_px);
    assign w_dy  = 33'(w_ny) - 33'(w_py);
    assign w_dz  = 33'(w_nz) - 33'(w_db);
    assign w_ngx = -33'(w_px);
    assign w_ngy = -33'(w_py);
    assign w_ngz = -33'(w_db);

    logic [CNT_W-1:0] w_cnt;
    always_comb begin
        if (w_vcount == '0) begin
            w_cnt = CNT_W'(1);
        end else if (w_vcount > CNT_W'(MAX_VERTICES)) begin
            w_cnt = CNT_W'(MAX_VERTICES);
        end else begin
            w_cnt = w_vcount;
        end
    end

    logic signed [COORD_W+1:0] w_sum;
    logic signed [COORD_W+1:0] w_sum_abs;
    assign w_sum = 34'(w_da)
                 + ((w_cnt >= CNT_W'(2)) ? 34'(w_db) : 34'sd0)
                 + ((w_cnt >= CNT_W'(3)) ? 34'(w_dc) : 34'sd0)
                 + ((w_cnt >= CNT_W'(4)) ? 34'(w_dd) : 34'sd0);
    assign w_sum_abs = w_sum[COORD_W+1] ? -w_sum : w_sum;

    logic signed [COORD_W:0] r_dx, r_dy, r_dz, r_ngx, r_ngy, r_ngz;
    // magnitude reaches 2^33 when four depths are all at the negative limit
    logic [COORD_W+1:0]      r_mag;
    logic                    r_sum_neg;
    logic                    r_div3;
    logic [1:0]              r_shift;
    logic [IDX_W-1:0]        r_index;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx      <= w_dx;
            r_dy      <= w_dy;
            r_dz      <= w_dz;
            r_ngx     <= w_ngx;
            r_ngy     <= w_ngy;
            r_ngz     <= w_ngz;
            r_mag     <= w_sum_abs;
            r_sum_neg <= w_sum[COORD_W+1];
            r_div3    <= (w_cnt == CNT_W'(3));
            r_shift   <= (w_cnt == CNT_W'(4)) ? 2'd2 : ((w_cnt == CNT_W'(2)) ? 2'd1 : 2'd0);
            r_index   <= w_index;
        end
    end

    // shared multiplier, registered product
    logic signed [MUL_W-1:0]  w_ma, w_mb;
    logic signed [PROD_W-1:0] r_prod;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_X: begin
                w_ma = MUL_W'(r_dx);
                w_mb = MUL_W'(r_ngx);
            end
            MUL_Y: begin
                w_ma = MUL_W'(r_dy);
                w_mb = MUL_W'(r_ngy);
            end
            MUL_Z: begin
                w_ma = MUL_W'(r_dz);
                w_mb = MUL_W'(r_ngz);
            end
            default: begin
                // three-term sums stay below 2^33, so the top bit is zero here
                w_ma = signed'(r_mag);
                w_mb = RECIP3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
    end

    // dot accumulator: each term fits 64 bits signed, the sum of three fits 66
    logic signed [ACC_W-1:0] r_acc;
    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod[ACC_W-1:0];
            ACC_ADD:  r_acc <= r_acc + r_prod[ACC_W-1:0];
            default:  r_acc <= r_acc;
        endcase
    end

    // mean depth, truncated toward zero
    logic [COORD_W-1:0] w_quot;
    logic [COORD_W-1:0] w_mean;
    assign w_quot = r_div3 ? r_prod[RECIP3_SH+COORD_W-1:RECIP3_SH]
                           : COORD_W'(r_mag >> r_shift);
    assign w_mean = r_sum_neg ? (~w_quot + COORD_W'(1)) : w_quot;

    logic [VCNT_W-1:0] r_vis_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_cnt <= '0;
        end else if (i_cmd.load && i_tuser) begin
            r_vis_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_vis_cnt <= r_vis_cnt + VCNT_W'(1);
        end
    end

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {6'd0, w_mean, r_vis_cnt[SLOT_W-1:0], r_index};
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;
    assign o_stat.dot_neg  = r_acc[ACC_W-1];
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    a_emit_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_acc[ACC_W-1])
        else $error("emit of a back-facing item");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_vis_cnt == $past(r_vis_cnt) + VCNT_W'(1))
        else $error("visible counter did not advance by one");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && (i_cmd.emit || i_cmd.mul_en)))
        else $error("new item loaded while one is in flight");

endmodule

### rtl/polygon_backface_cull_zaverage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_backface_cull_zaverage
// Back-face cull of one view-space polygon per item with mean vertex depth.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An accepted item first has its normal
// direction and depth sum formed and registered, then the three dot-product
// terms and the divide-by-three product pass in turn through the single
// shared 34x34 multiplier, and a final step decides. A back-facing item
// (negative dot product) gives no result; a visible one is written to the
// output register, where it waits for m_axis_tready while the next item is
// already taken. The final step stretches only while the output register
// still holds an untaken result.
// tuser bit 0 marks the first polygon of a model and clears the slot counter.
// ----------------------------------------------------------------------------
module polygon_backface_cull_zaverage
    import pbcz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // polygon_index, normal_x, normal_y, normal_z, pivot_x, pivot_y,
    // vertex_count, depth_a, depth_b, depth_c, depth_d, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    // first_polygon
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // visible_polygon, list_slot, mean_depth, zero pad
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pbcz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pbcz_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule
